@@ rtl/core/ctm_pkg.sv @@
package ctm_pkg;

  // Field widths
  localparam int unsigned CharW   = 8;
  localparam int unsigned MillisW = 27;
  localparam int unsigned RunW    = 7;   // a run keeps at most two digits
  localparam int unsigned LenW    = 2;   // run length saturates at three
  localparam int unsigned SecW    = 6;
  localparam int unsigned FracW   = 10;
  localparam int unsigned FcntW   = 4;   // fraction digit count saturates at ten
  localparam int unsigned HourW   = 5;
  localparam int unsigned MinW    = 6;

  // Scale factors
  localparam logic [MillisW-1:0] SECOND_MILLIS = MillisW'(1000);
  localparam logic [MillisW-1:0] MINUTE_MILLIS = MillisW'(60000);
  localparam logic [MillisW-1:0] HOUR_MILLIS   = MillisW'(3600000);
  localparam logic [FcntW-1:0]   FRAC_MAX_DIGITS = FcntW'(9);
  localparam logic [FcntW-1:0]   FRAC_CNT_SAT    = FcntW'(10);

  // Character codes
  localparam logic [CharW-1:0] CH_COLON = 8'h3A;
  localparam logic [CharW-1:0] CH_DOT   = 8'h2E;
  localparam logic [CharW-1:0] CH_SPACE = 8'h20;
  localparam logic [CharW-1:0] CH_TAB   = 8'h09;
  localparam logic [CharW-1:0] CH_CR    = 8'h0D;
  localparam logic [CharW-1:0] CH_ZERO  = 8'h30;
  localparam logic [CharW-1:0] CH_NINE  = 8'h39;

  typedef enum logic [3:0] {
    PH_WS     = 4'd0,
    PH_RUN1   = 4'd1,
    PH_COLON1 = 4'd2,
    PH_RUN2   = 4'd3,
    PH_COLON2 = 4'd4,
    PH_SEC1   = 4'd5,
    PH_SEC2   = 4'd6,
    PH_DOT    = 4'd7,
    PH_FRAC   = 4'd8,
    PH_END    = 4'd9
  } phase_t;

  typedef struct packed {
    logic [RunW-1:0] minute;
    logic [SecW-1:0] seconds;
    logic            exact;
  } resolve_t;

  // Settle on minute = first run, seconds from the second run
  function automatic resolve_t resolve_min_sec(input logic [RunW-1:0] first_val,
                                               input logic [RunW-1:0] second_val,
                                               input logic [LenW-1:0] second_len);
    resolve_t         r;
    logic             two;
    logic             multi;
    logic [SecW-1:0]  tens;
    multi = (second_len >= LenW'(2));
    two   = multi && (second_val <= RunW'(59));
    // tens digit of a two-digit run of 60 or more
    priority if (second_val >= RunW'(90)) tens = SecW'(9);
    else if (second_val >= RunW'(80))     tens = SecW'(8);
    else if (second_val >= RunW'(70))     tens = SecW'(7);
    else                                  tens = SecW'(6);
    r.minute = first_val;
    if (multi && !two) r.seconds = tens;
    else               r.seconds = SecW'(second_val);
    r.exact = (second_len == LenW'(1)) || ((second_len == LenW'(2)) && two);
    return r;
  endfunction

endpackage

@@ rtl/core/ctm_if.sv @@
interface ctm_in_if;
  logic                        valid;
  logic                        ready;
  logic [ctm_pkg::CharW-1:0]   char_code;
  logic                        has_char;
  logic                        last;

  modport source (output valid, output char_code, output has_char, output last,
                  input ready);
  modport sink (input valid, input char_code, input has_char, input last,
                output ready);
endinterface

interface ctm_out_if;
  logic                        valid;
  logic                        ready;
  logic [ctm_pkg::MillisW-1:0] millis;
  logic                        recognized;

  modport source (output valid, output millis, output recognized, input ready);
  modport sink (input valid, input millis, input recognized, output ready);
endinterface

@@ rtl/core/clock_time_text_to_millis.sv @@
// Clock-time text parser: reads a string one byte per transfer on chars and
// returns the time of day it starts with, in milliseconds, on result.
// Accepted forms after optional whitespace: [h:]m:s[.frac]. Hour 0-23 and
// minute 0-59 are runs of one or two digits; the fraction is truncated to
// milliseconds and ignored when longer than nine digits.
// chars carries char_code, has_char (0 for an end-only transfer) and last.
// One result transfer follows each chars transfer with last set; it carries
// millis and recognized (0 and 0 when no minute:second time matched).
// Throughput: one byte per cycle while chars.ready is high; the parse state
// updates on every accepted byte. After the last byte, the result is registered
// in stage 1, which resolves the fields, then in stage 2, which scales and sums them.
// Reset clears the parser and both output stages; chars is ready right away.
// When result stalls, the two stages fill and then chars.ready drops; the
// parser itself never stalls while a stage has room.
module clock_time_text_to_millis (
  input  logic             clk,
  input  logic             rst,
  ctm_in_if.sink           chars,
  ctm_out_if.source        result
);

  ctm_pkg::phase_t                phase, phase_next;
  logic [ctm_pkg::RunW-1:0]       run1_val, run1_val_next;
  logic [ctm_pkg::LenW-1:0]       run1_len, run1_len_next;
  logic [ctm_pkg::RunW-1:0]       run2_val, run2_val_next;
  logic [ctm_pkg::LenW-1:0]       run2_len, run2_len_next;
  logic [ctm_pkg::SecW-1:0]       sec_val, sec_val_next;
  logic [ctm_pkg::FracW-1:0]      frac_ms, frac_ms_next;
  logic [ctm_pkg::FcntW-1:0]      frac_cnt, frac_cnt_next;
  logic                           decided, decided_next;

  logic                           is_digit, is_space;
  logic [3:0]                     digit;
  ctm_pkg::resolve_t              res_feed, res_end;

  logic                           accept, adv1, adv2;
  logic                           stg_valid;
  logic [ctm_pkg::HourW-1:0]      stg_hour;
  logic [ctm_pkg::MinW-1:0]       stg_min;
  logic [ctm_pkg::SecW-1:0]       stg_sec;
  logic [ctm_pkg::FracW-1:0]      stg_frac;
  logic                           stg_rec;
  logic [ctm_pkg::RunW-1:0]       fin_hour, fin_min;
  logic [ctm_pkg::SecW-1:0]       fin_sec;
  logic [ctm_pkg::FracW-1:0]      fin_frac;

  logic                           out_valid;
  logic [ctm_pkg::MillisW-1:0]    out_millis;
  logic                           out_rec;
  logic [ctm_pkg::MillisW-1:0]    sum_millis;

  // Handshake: stage 2 is the output register, stage 1 holds resolved fields
  assign adv2        = !out_valid || result.ready;
  assign adv1        = !stg_valid || adv2;
  assign chars.ready = adv1;
  assign accept      = chars.valid && chars.ready;

  // Classify the incoming byte
  assign is_digit = (chars.char_code >= ctm_pkg::CH_ZERO) &&
                    (chars.char_code <= ctm_pkg::CH_NINE);
  assign digit    = is_digit ? 4'(chars.char_code - ctm_pkg::CH_ZERO) : 4'd0;
  assign is_space = (chars.char_code == ctm_pkg::CH_SPACE) ||
                    ((chars.char_code >= ctm_pkg::CH_TAB) &&
                     (chars.char_code <= ctm_pkg::CH_CR));

  assign res_feed = ctm_pkg::resolve_min_sec(run1_val, run2_val, run2_len);

  // Advance the parser by one byte
  always_comb begin
    phase_next    = phase;
    run1_val_next = run1_val;
    run1_len_next = run1_len;
    run2_val_next = run2_val;
    run2_len_next = run2_len;
    sec_val_next  = sec_val;
    frac_ms_next  = frac_ms;
    frac_cnt_next = frac_cnt;
    decided_next  = decided;
    if (chars.has_char) begin
      unique case (phase)
        ctm_pkg::PH_WS: begin
          if (is_space) begin
            phase_next = ctm_pkg::PH_WS;
          end else if (is_digit) begin
            run1_val_next = ctm_pkg::RunW'(digit);
            run1_len_next = ctm_pkg::LenW'(1);
            phase_next    = ctm_pkg::PH_RUN1;
          end else begin
            phase_next = ctm_pkg::PH_END;
          end
        end
        ctm_pkg::PH_RUN1: begin
          if (is_digit) begin
            if (run1_len < ctm_pkg::LenW'(2))
              run1_val_next = ctm_pkg::RunW'(run1_val * ctm_pkg::RunW'(10) +
                                             ctm_pkg::RunW'(digit));
            if (run1_len < ctm_pkg::LenW'(3)) run1_len_next = run1_len + ctm_pkg::LenW'(1);
          end else if ((chars.char_code == ctm_pkg::CH_COLON) &&
                       ((run1_len == ctm_pkg::LenW'(1)) ||
                        ((run1_len == ctm_pkg::LenW'(2)) &&
                         (run1_val <= ctm_pkg::RunW'(59))))) begin
            phase_next = ctm_pkg::PH_COLON1;
          end else begin
            phase_next = ctm_pkg::PH_END;
          end
        end
        ctm_pkg::PH_COLON1: begin
          if (is_digit) begin
            run2_val_next = ctm_pkg::RunW'(digit);
            run2_len_next = ctm_pkg::LenW'(1);
            phase_next    = ctm_pkg::PH_RUN2;
          end else begin
            phase_next = ctm_pkg::PH_END;
          end
        end
        ctm_pkg::PH_RUN2: begin
          if (is_digit) begin
            if (run2_len < ctm_pkg::LenW'(2))
              run2_val_next = ctm_pkg::RunW'(run2_val * ctm_pkg::RunW'(10) +
                                             ctm_pkg::RunW'(digit));
            if (run2_len < ctm_pkg::LenW'(3)) run2_len_next = run2_len + ctm_pkg::LenW'(1);
          end else if ((chars.char_code == ctm_pkg::CH_COLON) &&
                       ((run1_len == ctm_pkg::LenW'(1)) ||
                        ((run1_len == ctm_pkg::LenW'(2)) &&
                         (run1_val <= ctm_pkg::RunW'(23)))) &&
                       ((run2_len == ctm_pkg::LenW'(1)) ||
                        ((run2_len == ctm_pkg::LenW'(2)) &&
                         (run2_val <= ctm_pkg::RunW'(59))))) begin
            phase_next = ctm_pkg::PH_COLON2;
          end else begin
            run2_val_next = res_feed.minute;
            run1_val_next = '0;
            sec_val_next  = res_feed.seconds;
            decided_next  = 1'b1;
            phase_next    = ((chars.char_code == ctm_pkg::CH_DOT) && res_feed.exact) ?
                            ctm_pkg::PH_DOT : ctm_pkg::PH_END;
          end
        end
        ctm_pkg::PH_COLON2: begin
          if (is_digit) begin
            decided_next = 1'b1;
            sec_val_next = ctm_pkg::SecW'(digit);
            phase_next   = ctm_pkg::PH_SEC1;
          end else begin
            run2_val_next = res_feed.minute;
            run1_val_next = '0;
            sec_val_next  = res_feed.seconds;
            decided_next  = 1'b1;
            phase_next    = ctm_pkg::PH_END;
          end
        end
        ctm_pkg::PH_SEC1: begin
          if (is_digit) begin
            if (sec_val <= ctm_pkg::SecW'(5)) begin
              sec_val_next = ctm_pkg::SecW'(sec_val * ctm_pkg::SecW'(10) +
                                            ctm_pkg::SecW'(digit));
              phase_next   = ctm_pkg::PH_SEC2;
            end else begin
              phase_next = ctm_pkg::PH_END;
            end
          end else begin
            phase_next = (chars.char_code == ctm_pkg::CH_DOT) ?
                         ctm_pkg::PH_DOT : ctm_pkg::PH_END;
          end
        end
        ctm_pkg::PH_SEC2: begin
          phase_next = (chars.char_code == ctm_pkg::CH_DOT) ?
                       ctm_pkg::PH_DOT : ctm_pkg::PH_END;
        end
        ctm_pkg::PH_DOT: begin
          if (is_digit) begin
            frac_ms_next  = ctm_pkg::FracW'(ctm_pkg::FracW'(digit) * ctm_pkg::FracW'(100));
            frac_cnt_next = ctm_pkg::FcntW'(1);
            phase_next    = ctm_pkg::PH_FRAC;
          end else begin
            phase_next = ctm_pkg::PH_END;
          end
        end
        ctm_pkg::PH_FRAC: begin
          if (is_digit) begin
            if (frac_cnt == ctm_pkg::FcntW'(1))
              frac_ms_next = frac_ms + ctm_pkg::FracW'(ctm_pkg::FracW'(digit) *
                                                       ctm_pkg::FracW'(10));
            else if (frac_cnt == ctm_pkg::FcntW'(2))
              frac_ms_next = frac_ms + ctm_pkg::FracW'(digit);
            if (frac_cnt < ctm_pkg::FRAC_CNT_SAT) frac_cnt_next = frac_cnt + ctm_pkg::FcntW'(1);
          end else begin
            phase_next = ctm_pkg::PH_END;
          end
        end
        ctm_pkg::PH_END: begin
          phase_next = ctm_pkg::PH_END;
        end
        default: begin
          phase_next = ctm_pkg::PH_END;
        end
      endcase
    end
  end

  // Close an open minute:second match at the end of the string
  assign res_end = ctm_pkg::resolve_min_sec(run1_val_next, run2_val_next, run2_len_next);

  always_comb begin
    fin_hour = run1_val_next;
    fin_min  = run2_val_next;
    fin_sec  = sec_val_next;
    if ((phase_next == ctm_pkg::PH_RUN2) || (phase_next == ctm_pkg::PH_COLON2)) begin
      fin_hour = '0;
      fin_min  = res_end.minute;
      fin_sec  = res_end.seconds;
    end
    fin_frac = (frac_cnt_next <= ctm_pkg::FRAC_MAX_DIGITS) ? frac_ms_next : '0;
  end

  // Parser state: take the next byte, restart after the last one
  always_ff @(posedge clk) begin
    if (rst || (accept && chars.last)) begin
      phase    <= ctm_pkg::PH_WS;
      run1_val <= '0;
      run1_len <= '0;
      run2_val <= '0;
      run2_len <= '0;
      sec_val  <= '0;
      frac_ms  <= '0;
      frac_cnt <= '0;
      decided  <= 1'b0;
    end else if (accept) begin
      phase    <= phase_next;
      run1_val <= run1_val_next;
      run1_len <= run1_len_next;
      run2_val <= run2_val_next;
      run2_len <= run2_len_next;
      sec_val  <= sec_val_next;
      frac_ms  <= frac_ms_next;
      frac_cnt <= frac_cnt_next;
      decided  <= decided_next;
    end
  end

  // Stage 1: hold the resolved fields of a finished string
  always_ff @(posedge clk) begin
    if (rst) begin
      stg_valid <= 1'b0;
    end else if (adv1) begin
      stg_valid <= accept && chars.last;
    end
  end

  always_ff @(posedge clk) begin
    if (adv1 && accept && chars.last) begin
      stg_rec <= decided_next || (phase_next == ctm_pkg::PH_RUN2) ||
                 (phase_next == ctm_pkg::PH_COLON2);
      stg_hour <= ctm_pkg::HourW'(fin_hour);
      stg_min  <= ctm_pkg::MinW'(fin_min);
      stg_sec  <= fin_sec;
      stg_frac <= fin_frac;
    end
  end

  // Stage 2: scale and sum into the output register
  assign sum_millis = ctm_pkg::MillisW'(stg_hour) * ctm_pkg::HOUR_MILLIS +
                      ctm_pkg::MillisW'(stg_min)  * ctm_pkg::MINUTE_MILLIS +
                      ctm_pkg::MillisW'(stg_sec)  * ctm_pkg::SECOND_MILLIS +
                      ctm_pkg::MillisW'(stg_frac);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv2) begin
      out_valid <= stg_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv2 && stg_valid) begin
      out_millis <= stg_rec ? sum_millis : '0;
      out_rec    <= stg_rec;
    end
  end

  assign result.valid      = out_valid;
  assign result.millis     = out_millis;
  assign result.recognized = out_rec;

`ifndef SYNTHESIS
  // An unrecognised string always reports zero
  a_zero_when_unrecognised: assert property (@(posedge clk) disable iff (rst)
    (result.valid && !result.recognized) |-> (result.millis == '0))
    else $error("millis nonzero without a recognised time");

  // The parser restarts after the last byte
  a_restart_after_last: assert property (@(posedge clk) disable iff (rst)
    (accept && chars.last) |=> (phase == ctm_pkg::PH_WS))
    else $error("parser did not restart after last byte");

  // Once the match is over the parser stays put until the string ends
  a_end_sticks: assert property (@(posedge clk) disable iff (rst)
    ((phase == ctm_pkg::PH_END) && !(accept && chars.last)) |=>
    (phase == ctm_pkg::PH_END))
    else $error("parser left the end phase mid-string");

  // A finished string in stage 1 reaches the output register in the following cycle when stage 2 advances
  a_stage_to_output: assert property (@(posedge clk) disable iff (rst)
    (stg_valid && adv2) |=> result.valid)
    else $error("resolved fields lost between stages");
`endif

endmodule

@@ test/clock_time_text_to_millis_tb.sv @@
`timescale 1ns / 1ps

module clock_time_text_to_millis_tb;

  localparam int unsigned CycleLimit  = 200000;
  localparam int unsigned DrainCycles = 8;

  typedef struct packed {
    logic [ctm_pkg::MillisW-1:0] millis;
    logic                        recognized;
  } time_result_t;

  typedef struct packed {
    logic [ctm_pkg::CharW-1:0] char_code;
    logic                      has_char;
    logic                      last;
  } text_byte_t;

  bit   clk;
  logic rst = 1'b1;

  ctm_in_if  chars_bus ();
  ctm_out_if result_bus ();

  clock_time_text_to_millis u_top (
    .clk    (clk),
    .rst    (rst),
    .chars  (chars_bus),
    .result (result_bus)
  );

  // Parser state as the block should hold it
  ctm_pkg::phase_t           text_phase;
  logic [ctm_pkg::RunW-1:0]  run1_val;
  logic [ctm_pkg::LenW-1:0]  run1_len;
  logic [ctm_pkg::RunW-1:0]  run2_val;
  logic [ctm_pkg::LenW-1:0]  run2_len;
  logic [ctm_pkg::SecW-1:0]  sec_val;
  logic [ctm_pkg::FracW-1:0] frac_ms;
  logic [ctm_pkg::FcntW-1:0] frac_cnt;
  logic                      time_found;

  time_result_t pending_times[$];
  text_byte_t   text_buf[$];

  int unsigned errors;
  int unsigned cycles;
  int unsigned text_bytes_sent;
  int unsigned burst_left;
  int unsigned stall_left;
  bit          sender_gaps;
  bit          receiver_stalls;

  // Free-running clock
  always #1 clk = ~clk;

  // Abort a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("%0t: cycle limit reached", $time);
      $display("clock_time_text_to_millis_tb NOT OK");
      $finish;
    end
  end

  // Receiver: alternate ready runs of random length while stalls are on
  always @(negedge clk) begin
    if (!receiver_stalls) begin
      result_bus.ready <= 1'b1;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end else begin
      result_bus.ready <= !result_bus.ready;
      stall_left <= result_bus.ready ? $urandom_range(0, 6) : $urandom_range(0, 9);
    end
  end

  // Compare each result transfer against the oldest pending time
  always @(posedge clk) begin
    time_result_t want;
    if (!rst && result_bus.valid && result_bus.ready) begin
      if (pending_times.size() == 0) begin
        errors++;
        $display("%0t: unexpected result: expected none, actual millis %0d recognized %0b",
                 $time, result_bus.millis, result_bus.recognized);
      end else begin
        want = pending_times.pop_front();
        if (result_bus.millis !== want.millis) begin
          errors++;
          $display("%0t: millis mismatch: expected %0d, actual %0d",
                   $time, want.millis, result_bus.millis);
        end
        if (result_bus.recognized !== want.recognized) begin
          errors++;
          $display("%0t: recognized mismatch: expected %0b, actual %0b",
                   $time, want.recognized, result_bus.recognized);
        end
      end
    end
  end

  task automatic clear_parser();
    text_phase = ctm_pkg::PH_WS;
    run1_val   = '0;
    run1_len   = '0;
    run2_val   = '0;
    run2_len   = '0;
    sec_val    = '0;
    frac_ms    = '0;
    frac_cnt   = '0;
    time_found = 1'b0;
  endtask

  // Keep the first two digits of a run; the length saturates at three
  task automatic add_run_digit(inout logic [ctm_pkg::RunW-1:0] val,
                               inout logic [ctm_pkg::LenW-1:0] len,
                               input logic [3:0] d);
    if (len < 2) val = ctm_pkg::RunW'(val * 10 + d);
    if (len < 3) len = ctm_pkg::LenW'(len + 1);
  endtask

  // Take run 1 as the minute and the seconds from run 2
  task automatic settle_minute_second(output bit exact);
    logic [ctm_pkg::RunW-1:0] sv;
    logic [ctm_pkg::LenW-1:0] sl;
    bit                       two;
    sv  = run2_val;
    sl  = run2_len;
    two = (sl >= 2) && (sv / 10 <= 5);
    if (two || sl < 2) sec_val = ctm_pkg::SecW'(sv);
    else               sec_val = ctm_pkg::SecW'(sv / 10);
    run2_val   = run1_val;
    run1_val   = '0;
    time_found = 1'b1;
    exact      = (sl == 1) || (sl == 2 && two);
  endtask

  task automatic feed_text_byte(input logic [ctm_pkg::CharW-1:0] c);
    bit         dg;
    bit         sp;
    bit         exact;
    logic [3:0] d;
    dg = (c >= ctm_pkg::CH_ZERO) && (c <= ctm_pkg::CH_NINE);
    sp = (c == ctm_pkg::CH_SPACE) || (c >= ctm_pkg::CH_TAB && c <= ctm_pkg::CH_CR);
    d  = dg ? 4'(c - ctm_pkg::CH_ZERO) : 4'd0;
    case (text_phase)
      ctm_pkg::PH_WS: begin
        if (dg) begin
          run1_val   = ctm_pkg::RunW'(d);
          run1_len   = ctm_pkg::LenW'(1);
          text_phase = ctm_pkg::PH_RUN1;
        end else if (!sp) begin
          text_phase = ctm_pkg::PH_END;
        end
      end
      ctm_pkg::PH_RUN1: begin
        if (dg) add_run_digit(run1_val, run1_len, d);
        else if (c == ctm_pkg::CH_COLON &&
                 (run1_len == 1 || (run1_len == 2 && run1_val <= 59)))
          text_phase = ctm_pkg::PH_COLON1;
        else text_phase = ctm_pkg::PH_END;
      end
      ctm_pkg::PH_COLON1: begin
        if (dg) begin
          run2_val   = ctm_pkg::RunW'(d);
          run2_len   = ctm_pkg::LenW'(1);
          text_phase = ctm_pkg::PH_RUN2;
        end else begin
          text_phase = ctm_pkg::PH_END;
        end
      end
      ctm_pkg::PH_RUN2: begin
        if (dg) begin
          add_run_digit(run2_val, run2_len, d);
        end else if (c == ctm_pkg::CH_COLON &&
                     (run1_len == 1 || (run1_len == 2 && run1_val <= 23)) &&
                     (run2_len == 1 || (run2_len == 2 && run2_val <= 59))) begin
          text_phase = ctm_pkg::PH_COLON2;
        end else begin
          settle_minute_second(exact);
          text_phase = (c == ctm_pkg::CH_DOT && exact) ? ctm_pkg::PH_DOT : ctm_pkg::PH_END;
        end
      end
      ctm_pkg::PH_COLON2: begin
        if (dg) begin
          time_found = 1'b1;
          sec_val    = ctm_pkg::SecW'(d);
          text_phase = ctm_pkg::PH_SEC1;
        end else begin
          settle_minute_second(exact);
          text_phase = ctm_pkg::PH_END;
        end
      end
      ctm_pkg::PH_SEC1: begin
        if (dg) begin
          if (sec_val <= 5) begin
            sec_val    = ctm_pkg::SecW'(sec_val * 10 + d);
            text_phase = ctm_pkg::PH_SEC2;
          end else begin
            text_phase = ctm_pkg::PH_END;
          end
        end else begin
          text_phase = (c == ctm_pkg::CH_DOT) ? ctm_pkg::PH_DOT : ctm_pkg::PH_END;
        end
      end
      ctm_pkg::PH_SEC2:
        text_phase = (c == ctm_pkg::CH_DOT) ? ctm_pkg::PH_DOT : ctm_pkg::PH_END;
      ctm_pkg::PH_DOT: begin
        if (dg) begin
          frac_ms    = ctm_pkg::FracW'(d * 100);
          frac_cnt   = ctm_pkg::FcntW'(1);
          text_phase = ctm_pkg::PH_FRAC;
        end else begin
          text_phase = ctm_pkg::PH_END;
        end
      end
      ctm_pkg::PH_FRAC: begin
        if (dg) begin
          if (frac_cnt == 1)      frac_ms = ctm_pkg::FracW'(frac_ms + d * 10);
          else if (frac_cnt == 2) frac_ms = ctm_pkg::FracW'(frac_ms + d);
          if (frac_cnt < ctm_pkg::FRAC_CNT_SAT) frac_cnt = ctm_pkg::FcntW'(frac_cnt + 1);
        end else begin
          text_phase = ctm_pkg::PH_END;
        end
      end
      default: ;
    endcase
  endtask

  // Advance the parser by one accepted transfer; queue a time on the last one
  task automatic take_text_byte(input text_byte_t b);
    time_result_t r;
    int unsigned  total;
    bit           exact;
    if (b.has_char) feed_text_byte(b.char_code);
    if (b.last) begin
      if (text_phase == ctm_pkg::PH_RUN2 || text_phase == ctm_pkg::PH_COLON2)
        settle_minute_second(exact);
      total = 0;
      if (time_found)
        total = run1_val * ctm_pkg::HOUR_MILLIS + run2_val * ctm_pkg::MINUTE_MILLIS +
                sec_val * ctm_pkg::SECOND_MILLIS +
                ((frac_cnt <= ctm_pkg::FRAC_MAX_DIGITS) ? frac_ms : 0);
      r.millis     = ctm_pkg::MillisW'(total);
      r.recognized = time_found;
      pending_times.push_back(r);
      clear_parser();
    end
  endtask

  task automatic idle_sender(input int unsigned n);
    repeat (n) begin
      @(negedge clk);
      chars_bus.valid <= 1'b0;
    end
  endtask

  // Drive one byte and hold it until the transfer; insert burst gaps when enabled
  task automatic send_text_byte(input text_byte_t b);
    if (sender_gaps) begin
      if (burst_left == 0) begin
        idle_sender($urandom_range(1, 5));
        burst_left = $urandom_range(1, 12);
      end
      burst_left--;
    end
    @(negedge clk);
    chars_bus.valid     <= 1'b1;
    chars_bus.char_code <= b.char_code;
    chars_bus.has_char  <= b.has_char;
    chars_bus.last      <= b.last;
    do @(posedge clk); while (!chars_bus.ready);
    take_text_byte(b);
    if (b.has_char) text_bytes_sent++;
  endtask

  // Send a string; end it on its final byte or with an end-only transfer
  task automatic send_string(input string s, input bit end_only);
    text_byte_t b;
    for (int i = 0; i < s.len(); i++) begin
      b.char_code = s[i];
      b.has_char  = 1'b1;
      b.last      = !end_only && (i == s.len() - 1);
      send_text_byte(b);
    end
    if (end_only) begin
      b.char_code = ctm_pkg::CharW'($urandom_range(0, 255));
      b.has_char  = 1'b0;
      b.last      = 1'b1;
      send_text_byte(b);
    end
  endtask

  task automatic push_char(input logic [ctm_pkg::CharW-1:0] c);
    text_byte_t b;
    b.char_code = c;
    b.has_char  = 1'b1;
    b.last      = 1'b0;
    text_buf.push_back(b);
  endtask

  // Run of one to three digits, the leading one mostly kept in range
  task automatic push_run(input int unsigned max_tens);
    int unsigned n;
    n = $urandom_range(0, 9);
    n = (n < 4) ? 1 : (n < 8) ? 2 : 3;
    if (n == 1) begin
      push_char(ctm_pkg::CharW'(ctm_pkg::CH_ZERO + $urandom_range(0, 9)));
    end else begin
      push_char(ctm_pkg::CharW'(ctm_pkg::CH_ZERO +
                                (($urandom_range(0, 3) == 0) ? $urandom_range(0, 9)
                                                             : $urandom_range(0, max_tens))));
      repeat (n - 1) push_char(ctm_pkg::CharW'(ctm_pkg::CH_ZERO + $urandom_range(0, 9)));
    end
  endtask

  // Build one random string: mostly clock times, some noise and broken ones
  task automatic compose_time_text();
    int unsigned form;
    text_byte_t  b;
    text_buf.delete();
    form = $urandom_range(0, 9);
    if (form == 0) begin
      repeat ($urandom_range(1, 8)) push_char(ctm_pkg::CharW'($urandom_range(0, 255)));
    end else begin
      repeat ($urandom_range(0, 2))
        push_char(($urandom_range(0, 2) == 0) ? ctm_pkg::CH_SPACE :
                  ctm_pkg::CharW'(ctm_pkg::CH_TAB + $urandom_range(0, 4)));
      if (form <= 5) begin
        push_run(2);
        push_char(ctm_pkg::CH_COLON);
      end
      if (form <= 8) begin
        push_run(5);
        push_char(ctm_pkg::CH_COLON);
      end
      push_run(5);
      if ($urandom_range(0, 2) != 0) begin
        push_char(ctm_pkg::CH_DOT);
        repeat ($urandom_range(0, 11))
          push_char(ctm_pkg::CharW'(ctm_pkg::CH_ZERO + $urandom_range(0, 9)));
      end
      if ($urandom_range(0, 3) == 0)
        repeat ($urandom_range(1, 3)) push_char(ctm_pkg::CharW'($urandom_range(0, 255)));
      // corrupt one byte now and then
      if ($urandom_range(0, 7) == 0)
        text_buf[$urandom_range(0, text_buf.size() - 1)].char_code =
          ctm_pkg::CharW'($urandom_range(0, 255));
    end
    // drop in a byte the block must skip
    if ($urandom_range(0, 5) == 0) begin
      b.char_code = ctm_pkg::CharW'($urandom_range(0, 255));
      b.has_char  = 1'b0;
      b.last      = 1'b0;
      text_buf.insert($urandom_range(0, text_buf.size()), b);
    end
    if ($urandom_range(0, 3) == 0) begin
      b.char_code = ctm_pkg::CharW'($urandom_range(0, 255));
      b.has_char  = 1'b0;
      b.last      = 1'b1;
      text_buf.push_back(b);
    end else begin
      text_buf[text_buf.size() - 1].last = 1'b1;
    end
  endtask

  task automatic test_unmatched_text();
    text_byte_t b;
    b = '{char_code: 8'hFF, has_char: 1'b1, last: 1'b1};
    send_text_byte(b);
    b = '{char_code: 8'h00, has_char: 1'b1, last: 1'b0};
    send_text_byte(b);
    // a skipped digit must not start a time
    b = '{char_code: ctm_pkg::CharW'(ctm_pkg::CH_ZERO + 5), has_char: 1'b0, last: 1'b1};
    send_text_byte(b);
    send_string("", 1'b1);
  endtask

  task automatic test_full_clock_time();
    send_string("\t23:59:59.999", 1'b0);
  endtask

  task automatic test_hour_fallback();
    send_string("1:2:", 1'b0);
  endtask

  task automatic test_fraction_limits();
    send_string("5:6.0123456789", 1'b0);
    send_string("1:2.", 1'b0);
  endtask

  task automatic test_random_time_texts(input int unsigned n, input bit gaps, input bit stalls);
    int unsigned stop_at;
    sender_gaps     = gaps;
    receiver_stalls = stalls;
    stop_at         = text_bytes_sent + n;
    while (text_bytes_sent < stop_at) begin
      compose_time_text();
      foreach (text_buf[i]) send_text_byte(text_buf[i]);
    end
  endtask

  // Hold the sender off until every queued time has come out
  task automatic test_pause_until_drained();
    send_string("12:34:56.789", 1'b0);
    idle_sender(1);
    while (pending_times.size() != 0) @(posedge clk);
    send_string(" 7:08", 1'b0);
  endtask

  initial begin
    chars_bus.valid     = 1'b0;
    chars_bus.char_code = '0;
    chars_bus.has_char  = 1'b0;
    chars_bus.last      = 1'b0;
    result_bus.ready    = 1'b0;
    clear_parser();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_unmatched_text();
    test_full_clock_time();
    test_hour_fallback();
    test_fraction_limits();
    test_random_time_texts(400, 1'b0, 1'b0);
    test_random_time_texts(400, 1'b1, 1'b1);
    test_pause_until_drained();
    test_random_time_texts(400, 1'b1, 1'b0);
    test_random_time_texts(350, 1'b0, 1'b1);

    // Let the last results drain, then wait out DrainCycles for strays
    idle_sender(1);
    while (pending_times.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (errors == 0) begin
      $display("clock_time_text_to_millis_tb OK");
    end else begin
      $display("clock_time_text_to_millis_tb NOT OK");
    end
    $finish;
  end

endmodule
